// File: design/olb_pkg.sv
// Shared types and constants of the overlap linear blend unit.
`default_nettype none

package olb_pkg;

  // Image geometry and register widths
  localparam int unsigned MAX_IMAGE_WIDTH = 4096;
  localparam int unsigned COL_W  = 12;
  localparam int unsigned WID_W  = 13;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned NUM_W  = WID_W + PIX_W;   // numerator / remainder width
  localparam int unsigned NUM_CH = 3;               // blue, green, red

  // Pipeline depth: decode, product, four two-bit divide stages
  localparam int unsigned NUM_STAGES = 6;

  // Register indexes
  localparam logic [IDX_W-1:0] CFG_OVERLAP_START = 2'd0;
  localparam logic [IDX_W-1:0] CFG_FIRST_WIDTH   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_DARK_THRESH   = 2'd2;

  // Register reset values
  localparam logic [COL_W-1:0] START_RESET = '0;
  localparam logic [WID_W-1:0] WIDTH_RESET = WID_W'(MAX_IMAGE_WIDTH);
  localparam logic [PIX_W-1:0] DARK_RESET  = 8'd50;

  // Pixel source selection
  typedef enum logic [1:0] {
    MODE_FIRST = 2'b01,
    MODE_WARP  = 2'b10,
    MODE_BLEND = 2'b11
  } mode_e;

  typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_t;

  // One pipeline stage worth of payload
  typedef struct packed {
    mode_e                          mode;
    logic [WID_W-1:0]               w;
    logic [COL_W-1:0]               o;
    pix_t                           f;
    pix_t                           x;
    logic [NUM_CH-1:0][NUM_W-1:0]   rem;
    pix_t                           q;
  } stage_t;

endpackage

`default_nettype wire

// File: design/overlap_linear_blend_unit.sv
// Top level of the overlap linear blend unit: feathered RGB blend pipeline.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+----------------------------------
//  input   | in        | in_valid_i / in_stall_o    | column_i, first_*_i, warped_*_i
//  output  | out       | out_valid_o / out_stall_i  | out_blue_o, out_green_o, out_red_o
//  config  | in        | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// One item enters per cycle unless the input is stalled; its result is registered
// through decode, product and four restoring-divide stages of two quotient bits.
// The divider is the deep part: two dependent compare/subtract steps on 21 bits per
// stage, eight in all.
// Reset clears the stage valid bits and loads the register reset values.
// A stall on the output holds the last stage; bubbles ahead of it still fill,
// so the input is stalled only when every stage holds an item.
`default_nettype none

module overlap_linear_blend_unit (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // configuration
  input  wire                         cfg_we_i,
  input  wire [olb_pkg::IDX_W-1:0]    cfg_idx_i,
  input  wire [olb_pkg::CFG_W-1:0]    cfg_data_i,
  // input channel
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire [olb_pkg::COL_W-1:0]    column_i,
  input  wire [olb_pkg::PIX_W-1:0]    first_blue_i,
  input  wire [olb_pkg::PIX_W-1:0]    first_green_i,
  input  wire [olb_pkg::PIX_W-1:0]    first_red_i,
  input  wire [olb_pkg::PIX_W-1:0]    warped_blue_i,
  input  wire [olb_pkg::PIX_W-1:0]    warped_green_i,
  input  wire [olb_pkg::PIX_W-1:0]    warped_red_i,
  // output channel
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic [olb_pkg::PIX_W-1:0]   out_blue_o,
  output logic [olb_pkg::PIX_W-1:0]   out_green_o,
  output logic [olb_pkg::PIX_W-1:0]   out_red_o
);

  localparam int unsigned LAST = olb_pkg::NUM_STAGES - 1;

  // configuration registers
  logic [olb_pkg::COL_W-1:0] start_q;
  logic [olb_pkg::WID_W-1:0] width_q;
  logic [olb_pkg::PIX_W-1:0] dark_q;

  // pipeline
  logic [olb_pkg::NUM_STAGES-1:0] valid_q;
  logic [olb_pkg::NUM_STAGES-1:0] load;
  olb_pkg::stage_t                pipe_q [olb_pkg::NUM_STAGES];
  olb_pkg::stage_t                pipe_d [olb_pkg::NUM_STAGES];

  // decode helpers
  logic                      before_start;
  logic                      past_width;
  logic                      is_dark;
  olb_pkg::pix_t             in_f;
  olb_pkg::pix_t             in_x;

  // One restoring-divide step: {quotient bit, new remainder}
  function automatic logic [olb_pkg::NUM_W:0] div_step(
    input logic [olb_pkg::NUM_W-1:0] rem,
    input logic [olb_pkg::WID_W-1:0] w,
    input logic [2:0]                b
  );
    logic [olb_pkg::NUM_W-1:0] trial;
    trial = olb_pkg::NUM_W'(w) << b;
    if (rem >= trial) begin
      return {1'b1, rem - trial};
    end else begin
      return {1'b0, rem};
    end
  endfunction

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= olb_pkg::START_RESET;
      width_q <= olb_pkg::WIDTH_RESET;
      dark_q  <= olb_pkg::DARK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        olb_pkg::CFG_OVERLAP_START: start_q <= cfg_data_i[olb_pkg::COL_W-1:0];
        olb_pkg::CFG_FIRST_WIDTH:   width_q <= cfg_data_i[olb_pkg::WID_W-1:0];
        olb_pkg::CFG_DARK_THRESH:   dark_q  <= cfg_data_i[olb_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify the incoming column and pixel
  assign in_f = {first_red_i, first_green_i, first_blue_i};
  assign in_x = {warped_red_i, warped_green_i, warped_blue_i};
  assign before_start = column_i < start_q;
  assign past_width   = {1'b0, column_i} >= width_q;
  assign is_dark      = (warped_blue_i < dark_q) && (warped_green_i < dark_q) &&
                        (warped_red_i < dark_q);

  // Advance: a stage loads when empty or when its item moves on
  always_comb begin
    load[LAST] = !valid_q[LAST] || !out_stall_i;
    for (int s = LAST - 1; s >= 0; s--) begin
      load[s] = !valid_q[s] || load[s+1];
    end
  end

  assign in_stall_o = !load[0];

  // Next payload of every stage
  always_comb begin
    logic [olb_pkg::NUM_W:0]   step;
    logic [olb_pkg::WID_W-1:0] w_minus_o;
    logic [2:0]                b;

    // stage 0: decode mode and geometry
    pipe_d[0]     = '0;
    pipe_d[0].f   = in_f;
    pipe_d[0].x   = in_x;
    pipe_d[0].o   = column_i - start_q;
    pipe_d[0].w   = width_q - {1'b0, start_q};
    priority if (before_start) begin
      pipe_d[0].mode = olb_pkg::MODE_FIRST;
    end else if (past_width) begin
      pipe_d[0].mode = olb_pkg::MODE_WARP;
    end else if (is_dark) begin
      pipe_d[0].mode = olb_pkg::MODE_FIRST;
    end else begin
      pipe_d[0].mode = olb_pkg::MODE_BLEND;
    end

    // stage 1: weighted sum p1*(W-o) + p2*o
    pipe_d[1] = pipe_q[0];
    w_minus_o = pipe_q[0].w - {1'b0, pipe_q[0].o};
    for (int c = 0; c < olb_pkg::NUM_CH; c++) begin
      pipe_d[1].rem[c] = olb_pkg::NUM_W'(pipe_q[0].f[c] * w_minus_o) +
                         olb_pkg::NUM_W'(pipe_q[0].x[c] * pipe_q[0].o);
    end

    // stages 2..5: two quotient bits each, most significant first
    for (int s = 2; s < olb_pkg::NUM_STAGES; s++) begin
      pipe_d[s] = pipe_q[s-1];
      for (int k = 0; k < 2; k++) begin
        b = 3'(11 - 2 * s - k);
        for (int c = 0; c < olb_pkg::NUM_CH; c++) begin
          step                = div_step(pipe_d[s].rem[c], pipe_d[s].w, b);
          pipe_d[s].rem[c]    = step[olb_pkg::NUM_W-1:0];
          pipe_d[s].q[c][b]   = step[olb_pkg::NUM_W];
        end
      end
    end

    // last stage: pick the source pixel
    unique case (pipe_d[LAST].mode)
      olb_pkg::MODE_FIRST: pipe_d[LAST].q = pipe_d[LAST].f;
      olb_pkg::MODE_WARP:  pipe_d[LAST].q = pipe_d[LAST].x;
      olb_pkg::MODE_BLEND: ;
      default:             pipe_d[LAST].q = pipe_d[LAST].x;
    endcase
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (load[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int s = 1; s < olb_pkg::NUM_STAGES; s++) begin
        if (load[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  // Stage payload, held while the stage is stalled
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < olb_pkg::NUM_STAGES; s++) begin
      if (load[s]) begin
        pipe_q[s] <= pipe_d[s];
      end
    end
  end

  // Drive the output channel
  assign out_valid_o = valid_q[LAST];
  assign out_blue_o  = pipe_q[LAST].q[0];
  assign out_green_o = pipe_q[LAST].q[1];
  assign out_red_o   = pipe_q[LAST].q[2];

  // An empty entry stage never stalls the input
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[0] |-> !in_stall_o)
    else $error("input stalled with an empty entry stage");

  // An accepted item lands in the entry stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> valid_q[0])
    else $error("accepted item lost at the entry stage");

  // A full pipeline under output stall must stall the input
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&valid_q) && out_stall_i |-> in_stall_o)
    else $error("input taken while pipeline full and output stalled");

  // Blend numerator stays below 256*W so the quotient fits eight bits
  a_num_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] && pipe_q[1].mode == olb_pkg::MODE_BLEND |->
      pipe_q[1].rem[0] < {pipe_q[1].w, 8'b0} &&
      pipe_q[1].rem[1] < {pipe_q[1].w, 8'b0} &&
      pipe_q[1].rem[2] < {pipe_q[1].w, 8'b0})
    else $error("blend numerator out of range");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench of the overlap linear blend unit: directed and random pixels.
`timescale 1ns / 1ps

module tb_top;
  import olb_pkg::*;

  // Run shape
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned PHASE_ITEMS     = 250;
  localparam int unsigned DRAIN_CYCLES    = NUM_STAGES + 4;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned MAX_ERROR_LINES = 40;

  // Index with no register behind it
  localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    rgb_t             first;
    rgb_t             warped;
  } pixel_item_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             cfg_we_i       = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i      = '0;
  logic [CFG_W-1:0] cfg_data_i     = '0;
  logic             in_valid_i     = 1'b0;
  logic             in_stall_o;
  logic [COL_W-1:0] column_i       = '0;
  logic [PIX_W-1:0] first_blue_i   = '0;
  logic [PIX_W-1:0] first_green_i  = '0;
  logic [PIX_W-1:0] first_red_i    = '0;
  logic [PIX_W-1:0] warped_blue_i  = '0;
  logic [PIX_W-1:0] warped_green_i = '0;
  logic [PIX_W-1:0] warped_red_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i    = 1'b0;
  logic [PIX_W-1:0] out_blue_o;
  logic [PIX_W-1:0] out_green_o;
  logic [PIX_W-1:0] out_red_o;

  // Pixels waiting to be driven and blended pixels waiting to come out
  pixel_item_t pending_pixels[$];
  rgb_t        expected_pixels[$];
  pixel_item_t cur_pixel;

  // Shadow copy of the geometry registers
  logic [COL_W-1:0] blend_start;
  logic [WID_W-1:0] blend_width;
  logic [PIX_W-1:0] blend_thresh;

  bit          in_taken   = 1'b0;
  bit          idle_en    = 1'b0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned result_count   = 0;
  int unsigned error_count    = 0;
  int unsigned cfg_writes     = 0;
  int unsigned cycle_count    = 0;

  overlap_linear_blend_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .column_i       (column_i),
    .first_blue_i   (first_blue_i),
    .first_green_i  (first_green_i),
    .first_red_i    (first_red_i),
    .warped_blue_i  (warped_blue_i),
    .warped_green_i (warped_green_i),
    .warped_red_i   (warped_red_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_blue_o     (out_blue_o),
    .out_green_o    (out_green_o),
    .out_red_o      (out_red_o)
  );

  // Clock: 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Cross-fade of one channel, exact integer floor
  function automatic logic [PIX_W-1:0] fade_channel(input logic [PIX_W-1:0] p1,
                                                    input logic [PIX_W-1:0] p2,
                                                    input int unsigned offs,
                                                    input int unsigned span);
    int unsigned mix;
    mix = (p1 * (span - offs) + p2 * offs) / span;
    return mix[PIX_W-1:0];
  endfunction

  // Blended pixel for one item under the current geometry
  function automatic rgb_t feather_pixel(input pixel_item_t px);
    rgb_t        res;
    int unsigned span;
    int unsigned offs;
    logic        dark;
    if (px.column < blend_start) begin
      res = px.first;
    end else if ({1'b0, px.column} >= blend_width) begin
      res = px.warped;
    end else begin
      span = int'(blend_width) - int'(blend_start);
      offs = int'(px.column) - int'(blend_start);
      dark = px.warped.blue < blend_thresh && px.warped.green < blend_thresh &&
             px.warped.red < blend_thresh;
      if (dark) begin
        res = px.first;
      end else begin
        res.blue  = fade_channel(px.first.blue, px.warped.blue, offs, span);
        res.green = fade_channel(px.first.green, px.warped.green, offs, span);
        res.red   = fade_channel(px.first.red, px.warped.red, offs, span);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [PIX_W-1:0] exp_v,
                                 input logic [PIX_W-1:0] got_v);
    error_count++;
    if (error_count <= MAX_ERROR_LINES) begin
      $display("ERROR result %0d %s: expected %0d, got %0d", result_count, what, exp_v, got_v);
    end
  endtask

  // Check results, accept items, track register writes
  always @(posedge clk_i) begin : monitor
    rgb_t        exp_px;
    pixel_item_t acc_px;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
    if (!rst_ni) begin
      blend_start  = START_RESET;
      blend_width  = WIDTH_RESET;
      blend_thresh = DARK_RESET;
      in_taken     = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("arrived with nothing pending, blue", '0, out_blue_o);
        end else begin
          exp_px = expected_pixels.pop_front();
          if (out_blue_o !== exp_px.blue) report_mismatch("blue", exp_px.blue, out_blue_o);
          if (out_green_o !== exp_px.green) report_mismatch("green", exp_px.green, out_green_o);
          if (out_red_o !== exp_px.red) report_mismatch("red", exp_px.red, out_red_o);
        end
        result_count++;
      end
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        acc_px.column       = column_i;
        acc_px.first.blue   = first_blue_i;
        acc_px.first.green  = first_green_i;
        acc_px.first.red    = first_red_i;
        acc_px.warped.blue  = warped_blue_i;
        acc_px.warped.green = warped_green_i;
        acc_px.warped.red   = warped_red_i;
        expected_pixels.push_back(feather_pixel(acc_px));
        accepted_count++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OVERLAP_START: blend_start  = cfg_data_i[COL_W-1:0];
          CFG_FIRST_WIDTH:   blend_width  = cfg_data_i[WID_W-1:0];
          CFG_DARK_THRESH:   blend_thresh = cfg_data_i[PIX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Drive items from the pending queue, with random gaps
  always @(negedge clk_i) begin : drive_pixels
    logic        vld;
    pixel_item_t px;
    vld = in_valid_i && !in_taken;
    px  = cur_pixel;
    if (!rst_ni) begin
      vld = 1'b0;
    end else if (!vld && pending_pixels.size() != 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 7);
      end else begin
        px  = pending_pixels.pop_front();
        vld = 1'b1;
      end
    end
    cur_pixel      = px;
    in_valid_i     <= vld;
    column_i       <= px.column;
    first_blue_i   <= px.first.blue;
    first_green_i  <= px.first.green;
    first_red_i    <= px.first.red;
    warped_blue_i  <= px.warped.blue;
    warped_green_i <= px.warped.green;
    warped_red_i   <= px.warped.red;
  end

  // Stall the output in random bursts
  always @(negedge clk_i) begin : drive_stall
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic queue_pixel(input logic [COL_W-1:0] col, input rgb_t first,
                             input rgb_t warped);
    pixel_item_t px;
    px.column = col;
    px.first  = first;
    px.warped = warped;
    pending_pixels.push_back(px);
    queued_count++;
  endtask

  // Hold until every item is in and every result is out, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk_i);
    while (accepted_count != queued_count || expected_pixels.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] start_d, input logic [CFG_W-1:0] width_d,
                              input logic [CFG_W-1:0] thresh_d);
    wait_drained();
    cfg_write(CFG_OVERLAP_START, start_d);
    cfg_write(CFG_FIRST_WIDTH, width_d);
    cfg_write(CFG_DARK_THRESH, thresh_d);
  endtask

  initial begin : stimulus
    logic [COL_W-1:0] st;
    logic [WID_W-1:0] wd;
    logic [PIX_W-1:0] th;
    logic [COL_W-1:0] col;
    rgb_t             fp;
    rgb_t             wp;
    int unsigned      hi;
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    idle_en = 1'b1;

    // Reset geometry: overlap over the whole row, threshold 50
    queue_pixel(12'd0, 24'hFFFFFF, 24'h000000);
    queue_pixel(12'd0, 24'h000000, 24'hFFFFFF);
    queue_pixel(12'd4095, 24'h000000, 24'hFFFFFF);
    queue_pixel(12'd2048, {8'd255, 8'd0, 8'd128}, {8'd60, 8'd200, 8'd10});
    queue_pixel(12'd100, {8'd1, 8'd2, 8'd3}, {8'd49, 8'd49, 8'd49});
    queue_pixel(12'd100, {8'd1, 8'd2, 8'd3}, {8'd50, 8'd49, 8'd49});

    // Short overlap, threshold zero: nothing is dark
    set_geometry(13'd100, 13'd200, 13'd0);
    queue_pixel(12'd99, {8'd10, 8'd20, 8'd30}, {8'd200, 8'd210, 8'd220});
    queue_pixel(12'd100, {8'd10, 8'd20, 8'd30}, {8'd200, 8'd210, 8'd220});
    queue_pixel(12'd199, 24'hFFFFFF, 24'h000000);
    queue_pixel(12'd200, {8'd10, 8'd20, 8'd30}, {8'd200, 8'd210, 8'd220});
    queue_pixel(12'd150, 24'hFFFFFF, 24'h000000);

    // Empty overlap: start equal to width
    set_geometry(13'd300, 13'd300, 13'd50);
    queue_pixel(12'd299, {8'd7, 8'd8, 8'd9}, {8'd90, 8'd91, 8'd92});
    queue_pixel(12'd300, {8'd7, 8'd8, 8'd9}, {8'd90, 8'd91, 8'd92});
    queue_pixel(12'd4095, {8'd7, 8'd8, 8'd9}, {8'd90, 8'd91, 8'd92});

    // Zero width, threshold at its top
    set_geometry(13'd5, 13'd0, 13'd255);
    queue_pixel(12'd4, 24'hA5A5A5, 24'h5A5A5A);
    queue_pixel(12'd5, 24'hA5A5A5, 24'h5A5A5A);
    queue_pixel(12'd0, 24'hA5A5A5, 24'h5A5A5A);

    // Width past the image maximum
    set_geometry(13'd0, 13'd8191, 13'd255);
    queue_pixel(12'd4095, 24'h123456, {8'd254, 8'd254, 8'd254});
    queue_pixel(12'd4095, 24'h123456, {8'd254, 8'd254, 8'd255});
    queue_pixel(12'd0, 24'hFFFFFF, 24'hFFFFFF);

    // Write to the unused index must leave the geometry alone
    wait_drained();
    cfg_write(CFG_UNUSED, 13'h1FFF);
    queue_pixel(12'd1, 24'hFFFFFF, 24'hFFFFFF);
    queue_pixel(12'd4000, 24'h00FF00, 24'hFF00FF);

    // Random phases, each with its own geometry
    for (int p = 0; p < NUM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0:       st = '0;
        1:       st = 12'd4095;
        default: st = COL_W'($urandom_range(0, 4095));
      endcase
      case ($urandom_range(0, 7))
        0:       wd = 13'd4096;
        1:       wd = 13'd8191;
        2:       wd = '0;
        3:       wd = {1'b0, st};
        4:       wd = WID_W'(st + $urandom_range(1, 16));
        default: wd = WID_W'(st + $urandom_range(1, 4096));
      endcase
      case ($urandom_range(0, 3))
        0:       th = '0;
        1:       th = 8'd255;
        default: th = PIX_W'($urandom_range(0, 255));
      endcase
      set_geometry({1'($urandom_range(0, 1)), st}, wd, {5'($urandom), th});
      // No idling in the quiet last phase, nor in every third phase
      idle_en = (p != NUM_PHASES - 1) && (p % 3 != 2);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        fp = 24'($urandom);
        wp = 24'($urandom);
        case ($urandom_range(0, 9))
          0, 1: col = COL_W'($urandom);
          2: begin
            case ($urandom_range(0, 3))
              0:       col = st - 12'd1;
              1:       col = st;
              2:       col = wd[COL_W-1:0] - 12'd1;
              default: col = wd[COL_W-1:0];
            endcase
          end
          default: begin
            if (wd > {1'b0, st}) begin
              hi  = (wd > 13'd4096) ? 4095 : int'(wd) - 1;
              col = COL_W'($urandom_range(int'(st), hi));
            end else begin
              col = COL_W'($urandom);
            end
          end
        endcase
        // Dark warped pixels, and pixels one step from dark
        case ($urandom_range(0, 7))
          0, 1: begin
            if (th != 0) begin
              wp.blue  = PIX_W'($urandom_range(0, int'(th) - 1));
              wp.green = PIX_W'($urandom_range(0, int'(th) - 1));
              wp.red   = PIX_W'($urandom_range(0, int'(th) - 1));
            end
          end
          2: begin
            if (th != 0) begin
              wp.blue  = PIX_W'($urandom_range(0, int'(th) - 1));
              wp.green = PIX_W'($urandom_range(0, int'(th) - 1));
              wp.red   = th;
            end
          end
          default: ;
        endcase
        queue_pixel(col, fp, wp);
      end
    end

    wait_drained();
    $display("Drove %0d pixels through %0d register writes, %0d random geometries",
             accepted_count, cfg_writes, NUM_PHASES);
    $display("Checked %0d blended pixels, %0d field mismatches", result_count, error_count);
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/olb_pkg.sv
design/overlap_linear_blend_unit.sv
tb/tb_top.sv
